@@ rtl/core/sorted_timer_event_queue_defines.svh @@
// ----------------------------------------------------------------------------
// Sorted timer event queue: assertion macros
// Concurrent assertion helpers clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMER_EVENT_QUEUE_DEFINES_SVH
`define SORTED_TIMER_EVENT_QUEUE_DEFINES_SVH

`ifndef ASSERT_OFF

// Condition that holds in every cycle out of reset
`define STQ_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("sorted timer queue check failed");

// Same-cycle implication
`define STQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted timer queue check failed");

// Next-cycle implication
`define STQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted timer queue check failed");

`else

`define STQ_ASSERT(lbl, cond)
`define STQ_ASSERT_IMPL(lbl, ante, cons)
`define STQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ rtl/core/stq_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted timer event queue package
// Beat types, controller command and status groups, and shared constants.
// ----------------------------------------------------------------------------
package stq_pkg;

  // Default sizes
  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned TagBitsDef    = 8;

  // Field widths of the beats
  localparam int unsigned DlW  = 64;
  localparam int unsigned TagW = 8;
  localparam int unsigned OccW = 5;

  // Configuration port
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgIdxW  = CfgAddrW - 2;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0]  CFG_IDX_FREQ = '0;
  localparam logic [CfgDataW-1:0] FREQ_RESET   = 32'd62500000;

  // Item codes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_FIRE   = 1'b1;

  typedef struct packed {
    logic            mode;
    logic [DlW-1:0]  now_count;
    logic [DlW-1:0]  timeout;
    logic            in_seconds;
    logic [TagW-1:0] event_tag;
  } in_item_t;

  typedef struct packed {
    logic [TagW-1:0] out_tag;
    logic [DlW-1:0]  out_deadline;
    logic            fired;
    logic            queue_empty;
    logic            overflow;
    logic [OccW-1:0] occupancy;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic tick_add;
    logic mul_lo;
    logic mul_hi;
    logic mul_add;
    logic update;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_fire;
    logic in_secs;
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/core/stq_cfg.sv @@
// ----------------------------------------------------------------------------
// Sorted timer event queue configuration registers
// APB-style register file holding the counter frequency.
// ----------------------------------------------------------------------------
module stq_cfg
  import stq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output logic [CfgDataW-1:0] freq_o
);

  logic [CfgDataW-1:0] freq_q, freq_d;
  logic [CfgIdxW-1:0]  idx;
  logic                wr_en;

  assign idx    = paddr[CfgAddrW-1:2];
  assign wr_en  = psel && penable && pwrite && (idx == CFG_IDX_FREQ);
  assign pready = 1'b1;
  assign freq_o = freq_q;

  // Take a write on the access phase
  always_comb begin
    freq_d = freq_q;
    if (wr_en) begin
      freq_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= FREQ_RESET;
    end else begin
      freq_q <= freq_d;
    end
  end

  // Read back; unmapped addresses read zero
  always_comb begin
    prdata = '0;
    if (idx == CFG_IDX_FREQ) begin
      prdata = freq_q;
    end
  end

endmodule

@@ rtl/core/stq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sorted timer event queue controller
// Sequences deadline arithmetic and the queue update for one item at a time.
// ----------------------------------------------------------------------------
module stq_ctrl
  import stq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_TICK_ADD = 6'b000010,
    ST_MUL_LO   = 6'b000100,
    ST_MUL_HI   = 6'b001000,
    ST_MUL_ADD  = 6'b010000,
    ST_UPDATE   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (status_i.in_fire) begin
            state_d = ST_UPDATE;
          end else if (status_i.in_secs) begin
            state_d = ST_MUL_LO;
          end else begin
            state_d = ST_TICK_ADD;
          end
        end
      end
      ST_TICK_ADD: begin
        cmd_o.tick_add = 1'b1;
        state_d        = ST_UPDATE;
      end
      ST_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = ST_MUL_ADD;
      end
      ST_MUL_ADD: begin
        cmd_o.mul_add = 1'b1;
        state_d       = ST_UPDATE;
      end
      ST_UPDATE: begin
        // Hold until the result register is free
        if (status_i.out_free) begin
          cmd_o.update = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/stq_dpath.sv @@
// ----------------------------------------------------------------------------
// Sorted timer event queue datapath
// Deadline accumulator with a shared 32x32 multiplier, a row of sorted
// event cells that shift on insert and pop, and the result register.
// ----------------------------------------------------------------------------
module stq_dpath
  import stq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned TAG_BITS    = TagBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  in_item_t            in_item_i,
  input  logic [CfgDataW-1:0] freq_i,
  input  dp_cmd_t             cmd_i,
  output dp_status_t          status_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  // Latched item
  logic                mode_q;
  logic [DlW-1:0]      tmo_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [DlW-1:0]      acc_q, acc_d;
  logic [DlW-1:0]      prod_q, prod_d;

  // Event cells
  logic [DlW-1:0]      cell_dl_q  [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] cell_tag_q [QUEUE_DEPTH];
  logic [DlW-1:0]      cell_dl_d  [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] cell_tag_d [QUEUE_DEPTH];
  logic [DlW-1:0]      dl_dn  [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] tag_dn [QUEUE_DEPTH];
  logic [DlW-1:0]      dl_up  [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] tag_up [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] gt, gt_sh;

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;

  logic [31:0]     mul_b;
  logic [63:0]     mul_p;
  logic            full, empty;
  logic [TAG_BITS+TagW-1:0] tag_in_ext;
  logic [TagW+TAG_BITS-1:0] tag_out_ext;
  logic [OccW+CntW-1:0]     occ_ext;

  assign status_o.in_fire  = (in_item_i.mode == MODE_FIRE);
  assign status_o.in_secs  = in_item_i.in_seconds;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign full  = (count_q == CntW'(QUEUE_DEPTH));
  assign empty = (count_q == '0);

  assign tag_in_ext  = {{TAG_BITS{1'b0}}, in_item_i.event_tag};
  assign tag_out_ext = {{TagW{1'b0}}, cell_tag_q[0]};

  // Shared multiplier over the low and high timeout halves
  assign mul_b = cmd_i.mul_hi ? tmo_q[63:32] : tmo_q[31:0];
  assign mul_p = 64'(freq_i) * 64'(mul_b);

  // Deadline accumulation
  always_comb begin
    acc_d  = acc_q;
    prod_d = prod_q;
    if (cmd_i.load) begin
      acc_d = in_item_i.now_count;
    end
    if (cmd_i.tick_add) begin
      acc_d = acc_q + tmo_q;
    end
    if (cmd_i.mul_lo) begin
      prod_d = mul_p;
    end
    if (cmd_i.mul_hi) begin
      acc_d  = acc_q + prod_q;
      prod_d = {mul_p[31:0], 32'd0};
    end
    if (cmd_i.mul_add) begin
      acc_d = acc_q + prod_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= in_item_i.mode;
      tmo_q  <= in_item_i.timeout;
      tag_q  <= tag_in_ext[TAG_BITS-1:0];
    end
    acc_q  <= acc_d;
    prod_q <= prod_d;
  end

  // Neighbor taps and per-cell compare against the new deadline
  always_comb begin
    dl_dn[0]                = cell_dl_q[0];
    tag_dn[0]               = cell_tag_q[0];
    dl_up[QUEUE_DEPTH-1]    = cell_dl_q[QUEUE_DEPTH-1];
    tag_up[QUEUE_DEPTH-1]   = cell_tag_q[QUEUE_DEPTH-1];
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      dl_dn[i]    = cell_dl_q[i-1];
      tag_dn[i]   = cell_tag_q[i-1];
      dl_up[i-1]  = cell_dl_q[i];
      tag_up[i-1] = cell_tag_q[i];
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      gt[i] = (CntW'(i) < count_q) && (cell_dl_q[i] > acc_q);
    end
    gt_sh = {gt[QUEUE_DEPTH-2:0], 1'b0};
  end

  // Cell update: shift up behind the insert point, or shift down on pop
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      cell_dl_d[i]  = cell_dl_q[i];
      cell_tag_d[i] = cell_tag_q[i];
      if (cmd_i.update && (mode_q == MODE_INSERT) && !full) begin
        if (gt_sh[i]) begin
          cell_dl_d[i]  = dl_dn[i];
          cell_tag_d[i] = tag_dn[i];
        end else if (gt[i] || (CntW'(i) == count_q)) begin
          cell_dl_d[i]  = acc_q;
          cell_tag_d[i] = tag_q;
        end
      end else if (cmd_i.update && (mode_q == MODE_FIRE) && !empty) begin
        cell_dl_d[i]  = dl_up[i];
        cell_tag_d[i] = tag_up[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      cell_dl_q[i]  <= cell_dl_d[i];
      cell_tag_q[i] <= cell_tag_d[i];
    end
  end

  // Result beat and occupancy
  always_comb begin
    count_d = count_q;
    out_d   = out_q;
    if (cmd_i.update) begin
      out_d = '0;
      if (mode_q == MODE_INSERT) begin
        out_d.out_deadline = acc_q;
        out_d.overflow     = full;
        if (!full) begin
          count_d = count_q + 1'b1;
        end
      end else if (empty) begin
        out_d.queue_empty = 1'b1;
      end else begin
        out_d.fired        = 1'b1;
        out_d.out_tag      = tag_out_ext[TagW-1:0];
        out_d.out_deadline = cell_dl_q[0];
        count_d            = count_q - 1'b1;
      end
    end
    occ_ext = {{OccW{1'b0}}, count_d};
    if (cmd_i.update) begin
      out_d.occupancy = occ_ext[OccW-1:0];
    end
  end

  // Drop the valid flag once the beat is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.update) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

@@ rtl/core/sorted_timer_event_queue.sv @@
// ----------------------------------------------------------------------------
// Sorted timer event queue
// Holds timer events in deadline order; inserts compute a deadline from the
// counter value and timeout, fires pop the earliest event.
//
//   channel  | direction | handshake               | beat
//   ---------+-----------+-------------------------+-------------
//   in       | input     | in_valid_i / in_ready_o | in_item_t
//   out      | output    | out_valid_o/out_ready_i | out_item_t
//   config   | input     | psel/penable/pready     | pwdata/prdata
//
// An insert in ticks adds the timeout before the queue update, an insert in
// seconds takes two passes through the shared 32x32 multiplier and an add, a
// fire updates directly. The controller is ready again as a result registers.
// A result waiting on out_ready_i holds the queue update, not the accept.
// Reset empties the queue at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "sorted_timer_event_queue_defines.svh"

module sorted_timer_event_queue
  import stq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned TAG_BITS    = TagBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  logic [CfgDataW-1:0] freq;
  dp_cmd_t             cmd;
  dp_status_t          status;

  stq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .freq_o  (freq)
  );

  stq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  stq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .freq_i      (freq),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // Checks
  `STQ_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `STQ_ASSERT_IMPL(a_update_when_free, cmd.update, !out_valid_o || out_ready_i)
  `STQ_ASSERT_IMPL(a_flags_exclusive, out_valid_o,
                   $onehot0({out_item_o.fired, out_item_o.queue_empty, out_item_o.overflow}))
  `STQ_ASSERT_IMPL(a_tag_only_on_fire, out_valid_o && !out_item_o.fired,
                   out_item_o.out_tag == '0)

endmodule
